// ===== src/nwcs_pkg.sv =====
// Shared constants, codes and types of the nearest walkable cell search block.
// No dependencies; imported by nwcs_map and nearest_walkable_cell_search.
`default_nettype none

package nwcs_pkg;

	localparam int GRID_DIM  = 64;
	localparam int MEM_DEPTH = GRID_DIM * GRID_DIM;
	localparam int CW        = $clog2(GRID_DIM);
	localparam int AW        = $clog2(MEM_DEPTH);

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [1:0] REG_CELLS_X       = 2'd0;
	localparam logic [1:0] REG_CELLS_Z       = 2'd1;
	localparam logic [1:0] REG_SEARCH_RADIUS = 2'd2;

	typedef struct packed {
		logic          en;
		logic [AW-1:0] addr;
		logic          data;
	} map_wr_t;

endpackage

`default_nettype wire

// ===== src/nearest_walkable_cell_search.sv =====
// Top level of the nearest walkable cell search: stream ports, APB registers, ring scan.
// Depends on nwcs_pkg and nwcs_map.
`default_nettype none

// Keeps a 64x64 blocked/walkable bitmap. A write item (tuser = 0) sets one cell's
// blocked bit; writes outside the 64x64 store are dropped. A query item (tuser = 1)
// returns the start cell if it is inside the grid in use and walkable, otherwise
// the first walkable cell on square rings of radius 1 up to search_radius (dx outer,
// dz inner, candidates clamped into the grid), with found = 0 and the start
// coordinates if none is walkable. The bitmap's single read port tests one
// candidate per cycle; a query reads N candidates (start cell plus ring cells, at
// most (2R+1)^2), and its result can be held back by an output stall.
// After reset the bitmap is cleared to all blocked, and no item is accepted
// until the clear is done; APB writes are taken at any time.
module nearest_walkable_cell_search (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // cell_x[7:0], cell_z[15:8], blocked[16], zero pad
	input  wire logic        s_axis_tuser,  // action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // result_x[7:0], result_z[15:8]
	output logic             m_axis_tuser   // found
);
	import nwcs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	localparam logic signed [8:0] GRID_S = 9'(GRID_DIM);
	localparam logic [6:0]        GRID_7 = 7'(GRID_DIM);
	localparam logic [AW-1:0]     GRID_A = AW'(GRID_DIM);

	// registers
	logic [6:0] cells_x_q;
	logic [6:0] cells_z_q;
	logic [5:0] radius_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= 7'd10;
			cells_z_q <= 7'd10;
			radius_q  <= 6'd4;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CELLS_X:       cells_x_q <= pwdata[6:0];
				REG_CELLS_Z:       cells_z_q <= pwdata[6:0];
				REG_SEARCH_RADIUS: radius_q  <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CELLS_X:       prdata = {25'd0, cells_x_q};
			REG_CELLS_Z:       prdata = {25'd0, cells_z_q};
			REG_SEARCH_RADIUS: prdata = {26'd0, radius_q};
			default:           prdata = '0;
		endcase
	end

	// effective grid size
	logic [6:0] nx, nz;
	assign nx = (cells_x_q > GRID_7) ? GRID_7 : cells_x_q;
	assign nz = (cells_z_q > GRID_7) ? GRID_7 : cells_z_q;

	function automatic logic signed [8:0] clamp_coord(input logic signed [8:0] v,
		input logic [6:0] n);
		logic signed [8:0] ns;
		ns = $signed({2'b00, n});
		if (n == 7'd0 || v < 9'sd0) begin
			return 9'sd0;
		end else if (v >= ns) begin
			return ns - 9'sd1;
		end
		return v;
	endfunction

	// input unpack
	logic             in_acc;
	logic signed [7:0] in_x, in_z;
	logic             in_blk;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_x   = s_axis_tdata[7:0];
	assign in_z   = s_axis_tdata[15:8];
	assign in_blk = s_axis_tdata[16];

	state_t state_q;
	logic   map_ready;
	logic   rd_data;
	map_wr_t wr;
	logic [AW-1:0] rd_addr;

	logic signed [8:0] wx, wz;
	assign wx = {in_x[7], in_x};
	assign wz = {in_z[7], in_z};

	always_comb begin
		wr.en   = in_acc && (s_axis_tuser == ACT_WRITE) &&
			(wx >= 9'sd0) && (wx < GRID_S) && (wz >= 9'sd0) && (wz < GRID_S);
		wr.addr = AW'(wx[CW-1:0]) * GRID_A + AW'(wz[CW-1:0]);
		wr.data = in_blk;
	end

	nwcs_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.ready   (map_ready)
	);

	assign s_axis_tready = (state_q == ST_IDLE) && map_ready;

	// scan state
	logic signed [7:0] gx_q, gz_q;
	logic              start_q;
	logic              issue_done_q;
	logic [5:0]        r_q;
	logic signed [6:0] dx_q, dz_q;

	logic              valid_s1, inr_s1, last_s1;
	logic signed [8:0] cand_x_s1, cand_z_s1;

	logic              res_found_q;
	logic [7:0]        res_x_q, res_z_q;

	// candidate and next ring position
	logic signed [8:0] cx, cz;
	logic              c_inr, c_last, issue;
	logic signed [6:0] rs, nxt_dx, nxt_dz;
	logic [5:0]        nxt_r;
	logic              chk_hit, chk_end;

	always_comb begin
		rs = $signed({1'b0, r_q});
		if (start_q) begin
			cx     = {gx_q[7], gx_q};
			cz     = {gz_q[7], gz_q};
			c_last = (radius_q == 6'd0);
		end else begin
			cx     = clamp_coord({gx_q[7], gx_q} + {{2{dx_q[6]}}, dx_q}, nx);
			cz     = clamp_coord({gz_q[7], gz_q} + {{2{dz_q[6]}}, dz_q}, nz);
			c_last = (r_q == radius_q) && (dx_q == rs) && (dz_q == rs);
		end
		c_inr = (cx >= 9'sd0) && (cx < $signed({2'b00, nx})) &&
			(cz >= 9'sd0) && (cz < $signed({2'b00, nz}));
		rd_addr = AW'(cx[CW-1:0]) * GRID_A + AW'(cz[CW-1:0]);

		nxt_r  = r_q;
		nxt_dx = dx_q;
		nxt_dz = dz_q;
		if (start_q) begin
			nxt_r  = 6'd1;
			nxt_dx = -7'sd1;
			nxt_dz = -7'sd1;
		end else if (dz_q != rs) begin
			if (dx_q == -rs || dx_q == rs) begin
				nxt_dz = dz_q + 7'sd1;
			end else begin
				nxt_dz = rs;
			end
		end else if (dx_q != rs) begin
			nxt_dx = dx_q + 7'sd1;
			nxt_dz = -rs;
		end else begin
			nxt_r  = r_q + 6'd1;
			nxt_dx = -rs - 7'sd1;
			nxt_dz = -rs - 7'sd1;
		end

		chk_hit = valid_s1 && inr_s1 && !rd_data;
		chk_end = valid_s1 && (chk_hit || last_s1);
		issue   = (state_q == ST_SCAN) && !issue_done_q && !chk_end;
	end

	logic out_free;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			start_q       <= 1'b0;
			issue_done_q  <= 1'b0;
			valid_s1      <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			valid_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser == ACT_QUERY) begin
						start_q      <= 1'b1;
						issue_done_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						start_q <= 1'b0;
						if (c_last) begin
							issue_done_q <= 1'b1;
						end
					end
					if (chk_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			gx_q <= in_x;
			gz_q <= in_z;
		end
		if (issue) begin
			r_q       <= nxt_r;
			dx_q      <= nxt_dx;
			dz_q      <= nxt_dz;
			cand_x_s1 <= cx;
			cand_z_s1 <= cz;
			inr_s1    <= c_inr;
			last_s1   <= c_last;
		end
		if (state_q == ST_SCAN && chk_end) begin
			res_found_q <= chk_hit;
			res_x_q     <= chk_hit ? cand_x_s1[7:0] : gx_q;
			res_z_q     <= chk_hit ? cand_z_s1[7:0] : gz_q;
		end
		if (state_q == ST_DONE && out_free) begin
			m_axis_tuser <= res_found_q;
			m_axis_tdata <= {res_z_q, res_x_q};
		end
	end

	// checks
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> map_ready)
		else $error("item accepted during bitmap clear");

	a_s1_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SCAN))
		else $error("candidate in flight outside scan");

	a_end_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && chk_end) |=> (state_q == ST_DONE && !valid_s1))
		else $error("scan end did not move to result");

	a_found_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (!m_axis_tdata[7] && !m_axis_tdata[15]))
		else $error("found cell with negative coordinate");

endmodule

`default_nettype wire

// ===== src/nwcs_map.sv =====
// Blocked-cell bitmap: one-bit memory with a clearing sweep after reset.
// Depends on nwcs_pkg.
`default_nettype none

module nwcs_map (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire nwcs_pkg::map_wr_t wr,
	input  wire logic [nwcs_pkg::AW-1:0] rd_addr,
	output logic                 rd_data,
	output logic                 ready
);
	import nwcs_pkg::*;

	logic          mem [MEM_DEPTH];
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(MEM_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// every cell starts blocked
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= 1'b1;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

	assign ready = !clr_q;

endmodule

`default_nettype wire

// ===== tb/nearest_walkable_cell_search_test.sv =====
`timescale 1ns / 100ps
// Self-checking test of nearest_walkable_cell_search: stream items, APB register phases.
// Holds its own bitmap and ring-scan predictor; depends on nwcs_pkg and the block's RTL.

module nearest_walkable_cell_search_test;

	import nwcs_pkg::*;

	localparam int IDLE_LIMIT  = 60000;
	localparam int SETTLE_CYC  = 12;

	typedef struct packed {
		logic       found;
		logic [7:0] x;
		logic [7:0] z;
	} cell_answer_t;

	class walkable_map_board;
		bit           blocked_bits [MEM_DEPTH];
		int unsigned  size_x;
		int unsigned  size_z;
		int unsigned  radius;
		cell_answer_t pending_answers [$];
		int           errors;
		int           writes;
		int           queries;
		int           hits;

		function new();
			foreach (blocked_bits[i]) blocked_bits[i] = 1'b1;
			size_x  = 10;
			size_z  = 10;
			radius  = 4;
			errors  = 0;
			writes  = 0;
			queries = 0;
			hits    = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_CELLS_X:       size_x = value[6:0];
				REG_CELLS_Z:       size_z = value[6:0];
				REG_SEARCH_RADIUS: radius = value[5:0];
				default: ;
			endcase
		endfunction

		function bit open_cell(int x, int z, int nx, int nz);
			if (x < 0 || x >= nx || z < 0 || z >= nz)
				return 1'b0;
			return !blocked_bits[x * GRID_DIM + z];
		endfunction

		function int clamp_to(int v, int hi);
			if (v > hi) v = hi;
			if (v < 0) v = 0;
			return v;
		endfunction

		function void note_item(logic action, logic [7:0] x, logic [7:0] z, logic blk);
			int           gx, gz, nx, nz, cx, cz;
			bit           hit;
			cell_answer_t ans;
			gx = int'($signed(x));
			gz = int'($signed(z));
			if (action == ACT_WRITE) begin
				writes++;
				if (gx >= 0 && gx < GRID_DIM && gz >= 0 && gz < GRID_DIM)
					blocked_bits[gx * GRID_DIM + gz] = blk;
				return;
			end
			queries++;
			nx = (size_x > GRID_DIM) ? GRID_DIM : int'(size_x);
			nz = (size_z > GRID_DIM) ? GRID_DIM : int'(size_z);
			ans.x = x;
			ans.z = z;
			hit = open_cell(gx, gz, nx, nz);
			for (int r = 1; r <= int'(radius) && !hit; r++)
				for (int dx = -r; dx <= r && !hit; dx++)
					for (int dz = -r; dz <= r && !hit; dz++)
						if (dx == -r || dx == r || dz == -r || dz == r) begin
							cx = clamp_to(gx + dx, nx - 1);
							cz = clamp_to(gz + dz, nz - 1);
							if (open_cell(cx, cz, nx, nz)) begin
								hit   = 1'b1;
								ans.x = cx[7:0];
								ans.z = cz[7:0];
							end
						end
			ans.found = hit;
			if (hit) hits++;
			pending_answers = {pending_answers, ans};
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic found, logic [7:0] x, logic [7:0] z);
			cell_answer_t want;
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: found=%0b x=%0d z=%0d",
					found, $signed(x), $signed(z)));
				return;
			end
			want = pending_answers.pop_front();
			if (found !== want.found)
				report_mismatch($sformatf("found %0b, want %0b", found, want.found));
			if (x !== want.x)
				report_mismatch($sformatf("result_x %0d, want %0d", $signed(x), $signed(want.x)));
			if (z !== want.z)
				report_mismatch($sformatf("result_z %0d, want %0d", $signed(z), $signed(want.z)));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // cell_x[7:0], cell_z[15:8], blocked[16], zero pad
	logic        s_tuser = 1'b0;  // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // result_x[7:0], result_z[15:8]
	logic        m_tuser;  // found

	walkable_map_board board = new();
	int          burst_left = 0;
	int          phases = 0;
	int          idle_cycles = 0;
	int unsigned stall_mode = 0;
	int unsigned mode_left = 0;
	int unsigned cyc = 0;

	nearest_walkable_cell_search dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// accepted items and results
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			board.note_item(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[16]);
		if (m_tvalid && m_tready)
			board.check_result(m_tuser, m_tdata[7:0], m_tdata[15:8]);
	end

	// receiver stall pattern
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(16, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 99) < 55);
			2: m_tready <= (cyc[1:0] == 2'd0);
			default: m_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no progress for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	task apb_write(logic [1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task send_item(logic action, int x, int z, logic blk);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= action;
		s_tdata  <= {7'd0, blk, z[7:0], x[7:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	task wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task run_phase(int unsigned nx_reg, int unsigned nz_reg, int unsigned rad, int count,
			int open_pct);
		int nx, hi_x, hi_z, sel;
		wait_idle();
		apb_write(REG_CELLS_X, nx_reg);
		apb_write(REG_CELLS_Z, nz_reg);
		apb_write(REG_SEARCH_RADIUS, rad);
		phases++;
		nx   = (nx_reg > GRID_DIM) ? GRID_DIM : nx_reg;
		hi_x = (nx + 1 > GRID_DIM - 1) ? GRID_DIM - 1 : nx + 1;
		hi_z = (nz_reg + 1 > GRID_DIM - 1) ? GRID_DIM - 1 : nz_reg + 1;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				send_item(ACT_WRITE, $urandom_range(0, hi_x), $urandom_range(0, hi_z),
					$urandom_range(0, 99) >= open_pct);
			else if (sel < 48)
				send_item(ACT_WRITE, $urandom, $urandom, $urandom_range(0, 1));
			else if (sel < 90)
				send_item(ACT_QUERY, int'($urandom_range(0, hi_x + 4)) - 3,
					int'($urandom_range(0, hi_z + 4)) - 3, $urandom_range(0, 1));
			else
				send_item(ACT_QUERY, $urandom, $urandom, $urandom_range(0, 1));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset-time settings, starting from the all-blocked map
		apb_write(REG_CELLS_X, 10);
		apb_write(REG_CELLS_Z, 10);
		apb_write(REG_SEARCH_RADIUS, 4);
		phases++;
		send_item(ACT_QUERY, 0, 0, 1'b0);
		send_item(ACT_WRITE, 3, 4, 1'b0);
		send_item(ACT_QUERY, 3, 4, 1'b1);
		send_item(ACT_QUERY, 5, 5, 1'b0);
		send_item(ACT_WRITE, -1, 0, 1'b0);
		send_item(ACT_WRITE, 64, 3, 1'b0);
		send_item(ACT_WRITE, 0, -128, 1'b0);
		send_item(ACT_WRITE, 127, 127, 1'b0);
		send_item(ACT_QUERY, -1, 0, 1'b0);
		send_item(ACT_WRITE, 20, 20, 1'b0);
		send_item(ACT_QUERY, 20, 20, 1'b0);
		send_item(ACT_WRITE, 63, 63, 1'b0);
		send_item(ACT_QUERY, -128, -128, 1'b0);
		send_item(ACT_QUERY, 127, 127, 1'b0);
		send_item(ACT_QUERY, 127, -128, 1'b1);
		send_item(ACT_WRITE, 3, 4, 1'b1);
		send_item(ACT_QUERY, 3, 4, 1'b0);
		send_item(ACT_WRITE, 9, 9, 1'b0);
		send_item(ACT_QUERY, 127, 127, 1'b0);
		send_item(ACT_QUERY, 9, 0, 1'b0);
		send_item(ACT_QUERY, -128, 127, 1'b0);

		run_phase(64, 64, 63, 30, 2);
		run_phase(127, 100, 7, 150, 10);
		run_phase(0, 20, 3, 40, 50);
		run_phase(20, 0, 2, 30, 50);
		run_phase(1, 1, 0, 60, 50);
		run_phase(1, 64, 5, 80, 20);
		run_phase(64, 1, 5, 80, 20);
		run_phase(64, 64, 0, 80, 30);
		for (int p = 0; p < 6; p++)
			run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 12),
				80, $urandom_range(3, 40));
		wait_idle();

		$display("Ran %0d register settings: %0d writes, %0d queries (%0d found, %0d not found)",
			phases, board.writes, board.queries, board.hits, board.queries - board.hits);
		$display("Mismatches: %0d", board.errors);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
